FILE: src/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants for the pair force accumulator
// Holds the controller state encoding, the command and status bundles
// exchanged between controller and datapath, and the register map.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int CoordW = 32;
    localparam int IdW    = 20;
    localparam int AccW   = 48;
    localparam int FracW  = 24;

    localparam logic [CoordW-1:0] CutoffReset = 32'd167772;
    localparam logic [CoordW-1:0] MinRadReset = 32'd1678;
    localparam logic [CoordW-1:0] MassReset   = 32'd167772;

    // register word indices (paddr[3:2])
    localparam logic [1:0] RegCutoff = 2'd0;
    localparam logic [1:0] RegMinRad = 2'd1;
    localparam logic [1:0] RegMass   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_CMP,
        ST_SQRT,
        ST_QDIV,
        ST_TERM,
        ST_ADIV,
        ST_MDIV,
        ST_ACC,
        ST_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // capture the input request
        logic sq;          // form squares and distance
        logic cmp;         // clamp r2, decide skip
        logic sqrt_start;
        logic qdiv_start;
        logic term;        // build t and select axis
        logic adiv_start;
        logic mdiv_start;
        logic acc;         // add the term to one accumulator
        logic axis;        // 0: x, 1: y
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic skip;
        logic sqrt_done;
        logic div_done;
        logic last;
    } status_t;

endpackage

FILE: src/pfa_div.sv
// ----------------------------------------------------------------------------
// pfa_div: restoring divider, one quotient bit per cycle
// Divides a 112-bit dividend by a 64-bit divisor; the quotient is 112 bits.
// ----------------------------------------------------------------------------
module pfa_div
    import pfa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [111:0] num,
    input  logic [63:0]  den,
    output logic [111:0] quot,
    output logic         done
);

    logic [111:0] q_reg, q_next;
    logic [64:0]  rem_reg, rem_next;
    logic [63:0]  den_reg, den_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [64:0]  shifted;

    // shift one dividend bit in and try the subtraction
    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[63:0], q_reg[111]};
        if (start)
        begin
            q_next    = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                q_next   = {q_reg[110:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[110:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd111)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

FILE: src/pfa_sqrt.sv
// ----------------------------------------------------------------------------
// pfa_sqrt: bit-serial integer square root of a 64-bit value
// Produces one result bit per cycle.
// ----------------------------------------------------------------------------
module pfa_sqrt
    import pfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] rad,
    output logic [31:0] root,
    output logic        done
);

    logic [63:0] v_reg, v_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] one_reg, one_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] trial;

    // one step of the digit-by-digit root
    always_comb
    begin
        v_next    = v_reg;
        res_next  = res_reg;
        one_next  = one_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = res_reg + one_reg;
        if (start)
        begin
            v_next    = rad;
            res_next  = '0;
            one_next  = 64'h4000_0000_0000_0000;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + one_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            one_next = one_reg >> 2;
            if (one_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            one_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            one_reg  <= one_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
    end

    assign root = res_reg[31:0];
    assign done = done_reg;

endmodule

FILE: src/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl: sequencer for one pair request
// Steps through squares, range check, root, quotient and the two axis terms.
// ----------------------------------------------------------------------------
module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_load,
    input  logic    out_free,
    input  status_t sts,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    // advance the sequence and issue commands
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp = 1'b1;
                if (sts.skip)
                    state_next = ST_OUT;
                else
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sts.sqrt_done)
                begin
                    cmd.qdiv_start = 1'b1;
                    state_next     = ST_QDIV;
                end
            end
            ST_QDIV:
            begin
                if (sts.div_done)
                begin
                    axis_next  = 1'b0;
                    state_next = ST_TERM;
                end
            end
            ST_TERM:
            begin
                cmd.term       = 1'b1;
                state_next     = ST_ADIV;
            end
            ST_ADIV:
            begin
                if (sts.div_done)
                begin
                    cmd.mdiv_start = 1'b1;
                    state_next     = ST_MDIV;
                end
                else
                    cmd.adiv_start = 1'b0;
            end
            ST_MDIV:
            begin
                if (sts.div_done)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (axis_reg)
                    state_next = ST_OUT;
                else
                begin
                    axis_next  = 1'b1;
                    state_next = ST_TERM;
                end
            end
            ST_OUT:
            begin
                if (!sts.last)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        // term starts the product; the first division follows it
        if (state_reg == ST_TERM)
            cmd.adiv_start = 1'b1;
    end

endmodule

FILE: src/pfa_dp.sv
// ----------------------------------------------------------------------------
// pfa_dp: arithmetic datapath of the pair force accumulator
// Holds the captured pair, the squared distance, root, quotient, the shared
// divider and the two saturating accumulators.
// ----------------------------------------------------------------------------
module pfa_dp
    import pfa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output status_t                  sts,
    input  logic [CoordW-1:0]        self_x,
    input  logic [CoordW-1:0]        self_y,
    input  logic [IdW-1:0]           self_id,
    input  logic [CoordW-1:0]        other_x,
    input  logic [CoordW-1:0]        other_y,
    input  logic [IdW-1:0]           other_id,
    input  logic                     first_pair,
    input  logic                     last_pair,
    input  logic [CoordW-1:0]        cutoff_radius,
    input  logic [CoordW-1:0]        min_radius,
    input  logic [CoordW-1:0]        particle_mass,
    output logic signed [AccW-1:0]   sum_x,
    output logic signed [AccW-1:0]   sum_y
);

    localparam logic [48:0] MagCap = 49'h1_0000_0000_0000;
    localparam logic signed [AccW+1:0] SatHi = 50'sh7FFF_FFFF_FFFF;
    localparam logic signed [AccW+1:0] SatLo = -50'sh8000_0000_0000;

    logic [CoordW-1:0] dxm_reg, dym_reg;
    logic              dxn_reg, dyn_reg;
    logic              same_reg, last_reg;
    logic [63:0]       sqx_reg, sqy_reg;
    logic [63:0]       r2c_reg;
    logic [63:0]       cut2_reg, min2_reg;
    logic [111:0]      q_reg;
    logic              tneg_reg;
    logic [87:0]       prod_reg;
    logic              acap_reg;
    logic [48:0]       mag_reg;
    logic              qdiv_wait_reg, mdiv_wait_reg;
    logic              hi_step_reg, adiv_go_reg;
    logic signed [AccW-1:0] sx_reg, sx_next, sy_reg, sy_next;

    logic [32:0]  ddx, ddy;
    logic [64:0]  r2_sum;
    logic [63:0]  r2c_w;
    logic         skip_w;
    logic         sqrt_done, div_done;
    logic [31:0]  root;
    logic [111:0] quot;
    logic         div_start;
    logic [111:0] div_num;
    logic [63:0]  div_den;
    logic [63:0]  q_lo;
    logic [63:0]  tm;
    logic [31:0]  dsel;
    logic [63:0]  plo, phi;
    logic [63:0]  mass_eff;
    logic signed [AccW+1:0] sum_sel, term_s, total;

    assign ddx = {1'b0, other_x} - {1'b0, self_x};
    assign ddy = {1'b0, other_y} - {1'b0, self_y};

    // squared distance, skip decision and clamped r2 as seen in the compare state
    assign r2_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign skip_w = same_reg || r2_sum[64] || (r2_sum[63:0] > cut2_reg);

    always_comb
    begin
        r2c_w = r2_sum[63:0];
        if (r2c_w < min2_reg)
            r2c_w = min2_reg;
        if (r2c_w == 64'd0)
            r2c_w = 64'd1;
    end

    // capture the pair as signs and magnitudes
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dxn_reg  <= ddx[32];
            dyn_reg  <= ddy[32];
            dxm_reg  <= ddx[32] ? (~ddx[31:0] + 32'd1) : ddx[31:0];
            dym_reg  <= ddy[32] ? (~ddy[31:0] + 32'd1) : ddy[31:0];
            same_reg <= (self_id == other_id);
            last_reg <= last_pair;
        end
        if (cmd.sq)
        begin
            sqx_reg  <= {32'd0, dxm_reg} * {32'd0, dxm_reg};
            sqy_reg  <= {32'd0, dym_reg} * {32'd0, dym_reg};
            cut2_reg <= {32'd0, cutoff_radius} * {32'd0, cutoff_radius};
            min2_reg <= {32'd0, min_radius} * {32'd0, min_radius};
        end
        if (cmd.cmp)
            r2c_reg <= r2c_w;
        if (cmd.term && !cmd.axis)
            tneg_reg <= (q_lo > 64'h100_0000);
        // an A of 2^88 or more gives a term far above the cap for any mass
        if (cmd.mdiv_start)
            acap_reg <= (quot[111:88] != 24'd0);
        if (div_done && mdiv_wait_reg)
            mag_reg  <= (acap_reg || quot[111:48] != 64'd0) ? MagCap : {1'b0, quot[47:0]};
    end

    // track which division the shared divider is running
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qdiv_wait_reg <= 1'b0;
            mdiv_wait_reg <= 1'b0;
        end
        else
        begin
            if (cmd.qdiv_start)
                qdiv_wait_reg <= 1'b1;
            else if (div_done)
                qdiv_wait_reg <= 1'b0;
            if (cmd.mdiv_start)
                mdiv_wait_reg <= 1'b1;
            else if (div_done)
                mdiv_wait_reg <= 1'b0;
        end
    end

    // quotient q captured when the first division ends
    always_ff @(posedge clk)
    begin
        if (div_done && qdiv_wait_reg)
            q_reg <= quot;
    end

    assign q_lo = q_reg[63:0];
    assign tm   = (q_lo > 64'h100_0000) ? (q_lo - 64'h100_0000) : (64'h100_0000 - q_lo);

    // product of |t| and |d| for the current axis, low half then high half
    assign dsel = cmd.axis ? dym_reg : dxm_reg;
    assign plo  = {32'd0, tm[31:0]} * {32'd0, dsel};
    assign phi  = {32'd0, tm[63:32]} * {32'd0, dsel};

    always_ff @(posedge clk)
    begin
        if (cmd.term)
            prod_reg <= {24'd0, plo};
        else if (hi_step_reg)
            prod_reg <= prod_reg + {phi[55:0], 32'd0};
    end

    // hi_step and adiv_go hold the division start until the product is complete
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_step_reg <= 1'b0;
            adiv_go_reg <= 1'b0;
        end
        else
        begin
            hi_step_reg <= cmd.adiv_start;
            adiv_go_reg <= hi_step_reg;
        end
    end

    assign mass_eff = (particle_mass == 32'd0) ? 64'd1 : {32'd0, particle_mass};

    // share one divider among the quotient and both term divisions
    always_comb
    begin
        div_start = cmd.qdiv_start || cmd.mdiv_start || adiv_go_reg;
        if (cmd.qdiv_start)
        begin
            div_num = {56'd0, cutoff_radius, 24'd0};
            div_den = {32'd0, root};
        end
        else if (cmd.mdiv_start)
        begin
            div_num = {quot[87:0], 24'd0};
            div_den = mass_eff;
        end
        else
        begin
            div_num = {prod_reg, 24'd0};
            div_den = r2c_reg;
        end
    end

    pfa_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .rad   (r2c_w),
        .root  (root),
        .done  (sqrt_done)
    );

    pfa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (quot),
        .done  (div_done)
    );

    // saturating add of the signed term
    always_comb
    begin
        sum_sel = cmd.axis ? {{2{sy_reg[AccW-1]}}, sy_reg} : {{2{sx_reg[AccW-1]}}, sx_reg};
        term_s  = (tneg_reg != (cmd.axis ? dyn_reg : dxn_reg)) ?
                  -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
        total   = sum_sel + term_s;
        sx_next = sx_reg;
        sy_next = sy_reg;
        if (cmd.load && first_pair)
        begin
            sx_next = '0;
            sy_next = '0;
        end
        else if (cmd.acc)
        begin
            if (total > SatHi)
                total = SatHi;
            else if (total < SatLo)
                total = SatLo;
            if (cmd.axis)
                sy_next = total[AccW-1:0];
            else
                sx_next = total[AccW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= '0;
            sy_reg <= '0;
        end
        else
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
    end

    assign sum_x = sx_reg;
    assign sum_y = sy_reg;

    assign sts.skip      = skip_w;
    assign sts.sqrt_done = sqrt_done;
    assign sts.div_done  = div_done;
    assign sts.last      = last_reg;

endmodule

FILE: src/pair_force_accumulator.sv
// Sequence: an accepted in-range pair runs the root, five divisions on one shared
//   divider and the two products before its result; a skipped pair bypasses them.
//   A pair that is not last gives no result.
// Pairs: a new pair is accepted only once the sequencer is back in idle; a last
//   pair holds the sequencer while the output register is still full.
// Reset: asynchronous, active low; accumulators clear, registers take reset values.
// ----------------------------------------------------------------------------
// pair_force_accumulator: repulsive pair force summed over one particle
// Wraps the controller, datapath, register port and output register.
// ----------------------------------------------------------------------------
module pair_force_accumulator
    import pfa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [167:0] s_tdata,   // self_x, self_y, self_id, other_x, other_y, other_id
    input  logic         s_tlast,   // last_pair
    input  logic         s_tuser,   // first_pair
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // accel_x, accel_y
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [31:0] cut_reg, minr_reg, mass_reg;
    logic        ov_reg;
    logic [95:0] od_reg;
    cmd_t        cmd;
    status_t     sts;
    logic        out_load;
    logic signed [AccW-1:0] sum_x, sum_y;

    // register writes
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_reg  <= CutoffReset;
            minr_reg <= MinRadReset;
            mass_reg <= MassReset;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                RegCutoff: cut_reg  <= pwdata;
                RegMinRad: minr_reg <= pwdata;
                RegMass:   mass_reg <= pwdata;
                default:   ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (paddr[3:2])
            RegCutoff: prdata = cut_reg;
            RegMinRad: prdata = minr_reg;
            RegMass:   prdata = mass_reg;
            default:   prdata = '0;
        endcase
    end

    pfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_load (out_load),
        .out_free (!ov_reg || m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfa_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .self_x        (s_tdata[31:0]),
        .self_y        (s_tdata[63:32]),
        .self_id       (s_tdata[83:64]),
        .other_x       (s_tdata[115:84]),
        .other_y       (s_tdata[147:116]),
        .other_id      (s_tdata[167:148]),
        .first_pair    (s_tuser),
        .last_pair     (s_tlast),
        .cutoff_radius (cut_reg),
        .min_radius    (minr_reg),
        .particle_mass (mass_reg),
        .sum_x         (sum_x),
        .sum_y         (sum_y)
    );

    // hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (out_load)
            ov_reg <= 1'b1;
        else if (m_tready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            od_reg <= {sum_y, sum_x};
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!ov_reg || m_tready))
        else $error("result overwritten before taken");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.sq, cmd.cmp, cmd.acc}))
        else $error("conflicting datapath commands");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_force_accumulator testbench
// Drives neighbor pair requests with random gaps and output stalls. A local
// integer model of the cutoff force predicts each emitted acceleration pair,
// but for directed rows whose result is typed in. Covers a directed table, random
// neighbor groups and several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
    import pfa_pkg::*;

    localparam logic [1:0]  RegSpare   = 2'd3;       // outside the register map
    localparam logic [63:0] MagCap     = 64'd1 << 48;
    localparam logic [63:0] OneQ24     = 64'd1 << 24;
    localparam int          SettleCyc  = 700;
    localparam int          StallLimit = 5000;

    typedef struct packed {
        logic [31:0] self_x;
        logic [31:0] self_y;
        logic [19:0] self_id;
        logic [31:0] other_x;
        logic [31:0] other_y;
        logic [19:0] other_id;
        logic        first_pair;
        logic        last_pair;
    } pair_req_t;

    typedef struct packed {
        logic [47:0] accel_x;
        logic [47:0] accel_y;
    } accel_t;

    typedef struct {
        bit          extreme;    // run under the extreme register setting
        pair_req_t   req;
        bit          typed;      // result typed in below instead of predicted
        accel_t      res;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [167:0] s_tdata;   // self_x, self_y, self_id, other_x, other_y, other_id
    logic         s_tlast;   // last_pair
    logic         s_tuser;   // first_pair
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;   // accel_x, accel_y
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // predictor state
    logic [63:0]        cut_q;
    logic [63:0]        minr_q;
    logic [63:0]        mass_q;
    logic signed [63:0] acc_x;
    logic signed [63:0] acc_y;

    accel_t   accel_expected[$];
    int       errors;
    int       idle_cycles;
    bit       quiet;
    dir_row_t dir_rows[$];

    pair_force_accumulator uut (.*);

    // clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] one;
        res = 0;
        one = 64'd1 << 62;
        while (one > v)
            one = one >> 2;
        while (one != 0)
        begin
            if (v >= res + one)
            begin
                v   = v - (res + one);
                res = (res >> 1) + one;
            end
            else
                res = res >> 1;
            one = one >> 2;
        end
        return res;
    endfunction

    // magnitude of one force term, held at 2^48 when larger
    function automatic logic [63:0] force_mag(logic [63:0] tmag, logic [63:0] dmag,
                                              logic [63:0] r2, logic [63:0] mass);
        logic [127:0] prod;
        logic [127:0] scaled;
        logic [127:0] per_mass;
        prod   = 128'(tmag) * 128'(dmag);
        scaled = (prod << 24) / 128'(r2);
        if (scaled[127:103] != 0)
            return MagCap;
        per_mass = (scaled << 24) / 128'(mass);
        if (per_mass >= 128'(MagCap))
            return MagCap;
        return per_mass[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sum(logic signed [63:0] s,
                                                   logic signed [63:0] c);
        logic signed [63:0] v;
        v = s + c;
        if (v > 64'sh7FFF_FFFF_FFFF)
            return 64'sh7FFF_FFFF_FFFF;
        if (v < -64'sh8000_0000_0000)
            return -64'sh8000_0000_0000;
        return v;
    endfunction

    function automatic logic signed [63:0] add_axis(logic signed [63:0] acc, bit tneg,
                                                    logic [63:0] tmag,
                                                    logic signed [33:0] d,
                                                    logic [63:0] r2, logic [63:0] mass);
        logic [63:0]        dmag;
        logic signed [63:0] c;
        dmag = d < 0 ? 64'(-d) : 64'(d);
        c = force_mag(tmag, dmag, r2, mass);
        if (tneg != (d < 0))
            c = -c;
        return sat_sum(acc, c);
    endfunction

    // advance the accumulators by one pair; true when a result is emitted
    function automatic bit accumulate_pair(pair_req_t p, output accel_t res);
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic [64:0]        r2w;
        logic [63:0]        r2;
        logic [63:0]        minsq;
        logic [63:0]        mass;
        logic [63:0]        r;
        logic [63:0]        q;
        logic [63:0]        tmag;
        bit                 tneg;
        if (p.first_pair)
        begin
            acc_x = 0;
            acc_y = 0;
        end
        if (p.self_id != p.other_id)
        begin
            dx  = $signed({2'b0, p.other_x}) - $signed({2'b0, p.self_x});
            dy  = $signed({2'b0, p.other_y}) - $signed({2'b0, p.self_y});
            ax  = dx < 0 ? 32'(-dx) : 32'(dx);
            ay  = dy < 0 ? 32'(-dy) : 32'(dy);
            r2w = 65'(64'(ax) * 64'(ax)) + 65'(64'(ay) * 64'(ay));
            if (!r2w[64] && r2w[63:0] <= cut_q * cut_q)
            begin
                r2    = r2w[63:0];
                minsq = minr_q * minr_q;
                mass  = mass_q != 0 ? mass_q : 64'd1;
                if (r2 < minsq)
                    r2 = minsq;
                if (r2 == 0)
                    r2 = 1;
                r    = isqrt64(r2);
                q    = (cut_q << 24) / r;
                tneg = q > OneQ24;
                tmag = tneg ? q - OneQ24 : OneQ24 - q;
                acc_x = add_axis(acc_x, tneg, tmag, dx, r2, mass);
                acc_y = add_axis(acc_y, tneg, tmag, dy, r2, mass);
            end
        end
        res.accel_x = acc_x[47:0];
        res.accel_y = acc_y[47:0];
        return p.last_pair;
    endfunction

    // register write: setup then access phase
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            RegCutoff: cut_q  = 64'(val);
            RegMinRad: minr_q = 64'(val);
            RegMass:   mass_q = 64'(val);
            default:   ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold the sender until every result is back and the block has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        while (accel_expected.size() != 0)
            @(posedge clk);
        repeat (SettleCyc) @(posedge clk);
    endtask

    task automatic set_config(logic [31:0] cut, logic [31:0] minr, logic [31:0] mass);
        drain();
        write_reg(RegCutoff, cut);
        write_reg(RegMinRad, minr);
        write_reg(RegMass, mass);
    endtask

    task automatic send_pair(pair_req_t p, bit typed, accel_t typed_res);
        accel_t res;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.other_id, p.other_y, p.other_x,
                     p.self_id, p.self_y, p.self_x};
        s_tlast  <= p.last_pair;
        s_tuser  <= p.first_pair;
        do
            @(posedge clk);
        while (!s_tready);
        if (accumulate_pair(p, res))
            accel_expected.push_back(typed ? typed_res : res);
    endtask

    // one coordinate offset, mostly within the cutoff
    function automatic logic [31:0] near(logic [31:0] c);
        logic [63:0] span;
        logic [31:0] off;
        span = cut_q + (cut_q >> 2);
        if (span > 64'hFFFF_FFFF)
            span = 64'hFFFF_FFFF;
        off = $urandom_range(0, 32'(span));
        if ($urandom_range(0, 7) == 0)
            off = $urandom_range(0, 3);
        return $urandom_range(0, 1) ? c + off : c - off;
    endfunction

    task automatic random_groups(int count);
        pair_req_t p;
        accel_t    none;
        int        len;
        int        sent;
        none = '0;
        sent = 0;
        while (sent < count)
        begin
            len = $urandom_range(1, 6);
            p.self_x  = $urandom();
            p.self_y  = $urandom();
            p.self_id = 20'($urandom());
            for (int k = 0; k < len; k++)
            begin
                p.other_x    = near(p.self_x);
                p.other_y    = near(p.self_y);
                p.other_id   = 20'($urandom());
                p.first_pair = (k == 0);
                p.last_pair  = (k == len - 1);
                case ($urandom_range(0, 19))
                    0, 1: p.other_id = p.self_id;
                    2, 3:
                    begin
                        p.other_x = $urandom();
                        p.other_y = $urandom();
                    end
                    4, 5:
                    begin
                        p.first_pair = 1'($urandom_range(0, 1));
                        p.last_pair  = 1'($urandom_range(0, 1));
                    end
                    default: ;
                endcase
                send_pair(p, 1'b0, none);
                sent++;
            end
        end
    endtask

    function automatic void add_row(bit extreme, logic [31:0] sx, logic [31:0] sy,
                                    logic [19:0] sid, logic [31:0] ox, logic [31:0] oy,
                                    logic [19:0] oid, bit first, bit last, bit typed,
                                    logic [47:0] ex, logic [47:0] ey);
        dir_row_t row;
        row.extreme = extreme;
        row.req     = '{sx, sy, sid, ox, oy, oid, first, last};
        row.typed   = typed;
        row.res     = '{ex, ey};
        dir_rows.push_back(row);
    endfunction

    // receiver stalls
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (quiet || $urandom_range(0, 1))
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
        end
    end

    // compare each result with the oldest prediction
    always @(posedge clk)
    begin
        accel_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (accel_expected.size() == 0)
            begin
                $error("unexpected result accel_x=%h accel_y=%h",
                       m_tdata[47:0], m_tdata[95:48]);
                errors++;
            end
            else
            begin
                exp_res = accel_expected.pop_front();
                if (m_tdata[47:0] !== exp_res.accel_x)
                begin
                    $error("accel_x expected %h got %h", exp_res.accel_x, m_tdata[47:0]);
                    errors++;
                end
                if (m_tdata[95:48] !== exp_res.accel_y)
                begin
                    $error("accel_y expected %h got %h", exp_res.accel_y, m_tdata[95:48]);
                    errors++;
                end
            end
        end
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("** pair_force_accumulator: FAILED **");
            $finish;
        end
    end

    initial
    begin
        bit extreme_now;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        s_tuser     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        errors      = 0;
        idle_cycles = 0;
        quiet       = 1'b0;
        extreme_now = 1'b0;
        cut_q       = 64'(CutoffReset);
        minr_q      = 64'(MinRadReset);
        mass_q      = 64'(MassReset);
        acc_x       = 0;
        acc_y       = 0;

        // directed pairs at the reset setting
        add_row(0, 32'h100, 32'h100, 20'd7, 32'h200, 32'h80, 20'd7, 1, 1, 1, 0, 0);
        add_row(0, 0, 0, 20'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'd2, 1, 1, 1, 0, 0);
        add_row(0, 32'h0100_0000, 32'h0100_0000, 20'd1, 32'h0100_0000, 32'h0100_0000,
                20'd2, 1, 1, 1, 0, 0);
        add_row(0, 32'h0100_0000, 32'h0100_0000, 20'd3, 32'h0100_03E8, 32'h00FF_F830,
                20'd4, 1, 1, 0, 0, 0);
        add_row(0, 32'h0200_0000, 32'h0300_0000, 20'd5, 32'h0200_1000, 32'h0300_2000,
                20'd6, 1, 0, 0, 0, 0);
        add_row(0, 32'h0200_0000, 32'h0300_0000, 20'd5, 32'h0200_0010, 32'h0300_0020,
                20'd5, 0, 0, 0, 0, 0);
        add_row(0, 32'h0200_0000, 32'h0300_0000, 20'd5, 32'h01FF_F000, 32'h0300_0400,
                20'd8, 0, 1, 0, 0, 0);
        add_row(0, 32'h0400_0000, 32'h0400_0000, 20'd9, 32'h0400_0100, 32'h0400_0000,
                20'd10, 1, 0, 0, 0, 0);
        add_row(0, 32'h0400_0000, 32'h0400_0000, 20'd9, 32'h7000_0000, 32'h0400_0000,
                20'd11, 0, 1, 0, 0, 0);
        add_row(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 32'hFFFF_FF9C, 32'hFFFF_FFFF,
                20'd0, 1, 1, 0, 0, 0);
        add_row(0, 32'h10, 32'h10, 20'd0, 32'h11, 32'h10, 20'hFFFFF, 1, 1, 0, 0, 0);
        // extreme setting: widest cutoff, no distance clamp, zero mass
        add_row(1, 0, 0, 20'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'd2, 1, 1, 1, 0, 0);
        add_row(1, 32'd5, 32'd5, 20'd1, 32'd5, 32'd5, 20'd2, 1, 1, 1, 0, 0);
        add_row(1, 32'd5, 32'd5, 20'd1, 32'd6, 32'd5, 20'd2, 1, 1, 1,
                48'h8000_0000_0000, 0);
        add_row(1, 32'd5, 32'd5, 20'd1, 32'd4, 32'd5, 20'd2, 1, 1, 1,
                48'h7FFF_FFFF_FFFF, 0);
        add_row(1, 32'h8000_0000, 32'h8000_0000, 20'd3, 32'hC000_0000, 32'h4000_0000,
                20'd4, 1, 1, 0, 0, 0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].extreme && !extreme_now)
            begin
                set_config(32'hFFFF_FFFF, 32'd0, 32'd0);
                extreme_now = 1'b1;
            end
            send_pair(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
        end

        // random neighbor groups over several settings
        random_groups(100);
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_groups(80);
        set_config(32'd1, 32'd1, 32'd1);
        random_groups(80);
        drain();
        write_reg(RegSpare, 32'hDEAD_BEEF);
        set_config(32'h0100_0000, 32'h0010_0000, 32'h0100_0000);
        random_groups(200);
        set_config(32'h0000_8000, 32'd0, 32'hFFFF_FFFF);
        random_groups(100);
        set_config(CutoffReset, MinRadReset, MassReset);
        random_groups(100);
        quiet = 1'b1;
        random_groups(140);

        drain();
        if (errors == 0)
            $display("** pair_force_accumulator: PASSED **");
        else
            $display("** pair_force_accumulator: FAILED **");
        $finish;
    end

endmodule
